### src/pcse_pkg.sv
// Shared constants, operation codes and interface types for the coefficient store core.
`timescale 1ns / 1ps
`default_nettype none

package pcse_pkg;

    localparam int NUM_TERMS = 32;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = $clog2(NUM_TERMS);

    localparam logic [2:0] OP_SET   = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_EVAL  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    // request to the coefficient store
    typedef struct packed {
        logic                    rd_en;
        logic [IDX_W-1:0]        rd_addr;
        logic                    wr_en;
        logic [IDX_W-1:0]        wr_addr;
        logic signed [31:0]      wr_data;
        logic                    clear;
    } coef_req_t;

    // control of the shared multiply/scale/add unit
    typedef struct packed {
        logic mul_en;
        logic scale_en;
        logic use_scaled;
    } mac_ctl_t;

endpackage

`default_nettype wire

### src/polynomial_coefficient_store_eval_core.sv
// Top level: command sequencer for the polynomial coefficient store and Horner evaluator.
//
// A command beat is taken when start is high and busy is low; every command returns exactly
// one result beat, shown for a single cycle with done high, and the receiver cannot stall it,
// so result_value, top_degree and overflow_flag must be captured in the done cycle. Read, clear
// and unused codes pass through S_EXEC straight to the done cycle; set and add then refind the
// degree by a top-down scan of the nonzero flags, one entry per cycle, stopping at the first
// nonzero term; evaluate runs one Horner step per term from the top index down, each through
// the one shared unit in three steps: multiply, round/saturate, then add the coefficient.
// A new command may be accepted in the done cycle. Coefficients are signed Q16.16, sums and
// rescaled products saturate to 32 bits, and any saturation raises overflow_flag.
`timescale 1ns / 1ps
`default_nettype none

module polynomial_coefficient_store_eval_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         operation,
    input  wire logic [4:0]         term_index,
    input  wire logic signed [31:0] coef_value,
    input  wire logic signed [31:0] point,
    output logic                    done,
    output logic signed [31:0]      result_value,
    output logic [4:0]              top_degree,
    output logic                    overflow_flag
);

    localparam int IW = pcse_pkg::IDX_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;   // store read data ready, run the command
    localparam logic [2:0] S_SCAN = 3'd2;   // degree search after set/add
    localparam logic [2:0] S_EMUL = 3'd3;   // Horner: acc * x, fetch coef
    localparam logic [2:0] S_ESCL = 3'd4;   // Horner: round and clamp product
    localparam logic [2:0] S_EADD = 3'd5;   // Horner: add coef
    localparam logic [2:0] S_DONE = 3'd6;   // result beat

    localparam logic [IW-1:0] TOP_IDX = IW'(pcse_pkg::NUM_TERMS - 1);

    logic [2:0]          state_reg, state_next;
    logic [IW-1:0]       cnt_reg, cnt_next;
    logic [4:0]          degree_reg, degree_next;
    logic signed [31:0]  result_reg, result_next;
    logic                ovf_reg, ovf_next;
    logic signed [31:0]  acc_reg, acc_next;

    // command fields captured at accept
    logic [2:0]          op_reg;
    logic [IW-1:0]       addr_reg;
    logic                in_table_reg;
    logic signed [31:0]  cval_reg;
    logic signed [31:0]  x_reg;

    logic                accept;
    pcse_pkg::coef_req_t req;
    pcse_pkg::mac_ctl_t  mac_ctl;
    logic signed [31:0]  rd_data;
    logic [pcse_pkg::NUM_TERMS-1:0] nz;
    logic signed [31:0]  sum;
    logic                sum_ovf;
    logic                scale_ovf;

    assign busy   = (state_reg != S_IDLE) && (state_reg != S_DONE);
    assign accept = start && !busy;

    pcse_coef_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data),
        .nz      (nz)
    );

    pcse_mac u_mac
    (
        .clk       (clk),
        .ctl       (mac_ctl),
        .mul_a     (acc_reg),
        .mul_b     (x_reg),
        .operand   (cval_reg),
        .coef      (rd_data),
        .sum       (sum),
        .sum_ovf   (sum_ovf),
        .scale_ovf (scale_ovf)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        degree_next = degree_reg;
        result_next = result_reg;
        ovf_next    = ovf_reg;
        acc_next    = acc_reg;

        req.rd_en   = 1'b0;
        req.rd_addr = cnt_reg;
        req.wr_en   = 1'b0;
        req.wr_addr = addr_reg;
        req.wr_data = cval_reg;
        req.clear   = 1'b0;

        mac_ctl.mul_en     = 1'b0;
        mac_ctl.scale_en   = 1'b0;
        mac_ctl.use_scaled = 1'b0;

        case (state_reg)
            S_IDLE, S_DONE:
            begin
                if (accept)
                begin
                    // fetch the addressed entry so set/add/read see it in S_EXEC
                    state_next  = S_EXEC;
                    result_next = 32'sd0;
                    ovf_next    = 1'b0;
                    req.rd_en   = 1'b1;
                    req.rd_addr = IW'(term_index);
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_EXEC:
            begin
                case (op_reg)
                    pcse_pkg::OP_SET:
                    begin
                        if (in_table_reg)
                        begin
                            req.wr_en  = 1'b1;
                            cnt_next   = TOP_IDX;
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    pcse_pkg::OP_ADD:
                    begin
                        if (in_table_reg)
                        begin
                            req.wr_en   = 1'b1;
                            req.wr_data = sum;
                            ovf_next    = sum_ovf;
                            cnt_next    = TOP_IDX;
                            state_next  = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    pcse_pkg::OP_EVAL:
                    begin
                        acc_next   = 32'sd0;
                        cnt_next   = TOP_IDX;
                        state_next = S_EMUL;
                    end
                    pcse_pkg::OP_READ:
                    begin
                        result_next = in_table_reg ? rd_data : 32'sd0;
                        state_next  = S_DONE;
                    end
                    pcse_pkg::OP_CLEAR:
                    begin
                        req.clear   = 1'b1;
                        degree_next = 5'd0;
                        state_next  = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SCAN:
            begin
                // highest nonzero term wins; all-zero table ends at index 0
                if (nz[cnt_reg] || (cnt_reg == '0))
                begin
                    degree_next = 5'(cnt_reg);
                    state_next  = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - IW'(1);
                end
            end

            S_EMUL:
            begin
                mac_ctl.mul_en = 1'b1;
                req.rd_en      = 1'b1;
                state_next     = S_ESCL;
            end

            S_ESCL:
            begin
                mac_ctl.scale_en = 1'b1;
                state_next       = S_EADD;
            end

            S_EADD:
            begin
                mac_ctl.use_scaled = 1'b1;
                acc_next = sum;
                ovf_next = ovf_reg | scale_ovf | sum_ovf;
                if (cnt_reg == '0)
                begin
                    result_next = sum;
                    state_next  = S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg - IW'(1);
                    state_next = S_EMUL;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            degree_reg <= 5'd0;
        end
        else
        begin
            state_reg  <= state_next;
            degree_reg <= degree_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
        ovf_reg    <= ovf_next;
        acc_reg    <= acc_next;
        if (accept)
        begin
            op_reg       <= operation;
            addr_reg     <= IW'(term_index);
            in_table_reg <= (32'(term_index) < 32'(pcse_pkg::NUM_TERMS));
            cval_reg     <= coef_value;
            x_reg        <= point;
        end
    end

    assign done          = (state_reg == S_DONE);
    assign result_value  = result_reg;
    assign top_degree    = degree_reg;
    assign overflow_flag = ovf_reg;

endmodule

`default_nettype wire

### src/pcse_coef_store.sv
// Coefficient memory with per-entry nonzero flags; unflagged entries read as zero.
`timescale 1ns / 1ps
`default_nettype none

module pcse_coef_store
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pcse_pkg::coef_req_t           req,
    output logic signed [31:0]                 rd_data,
    output logic [pcse_pkg::NUM_TERMS-1:0]     nz
);

    logic signed [31:0]                mem [pcse_pkg::NUM_TERMS];
    logic signed [31:0]                mem_rd_reg;
    logic                              nz_rd_reg;
    logic [pcse_pkg::NUM_TERMS-1:0]    nz_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_rd_reg <= mem[req.rd_addr];
        end
    end

    // nonzero flags double as valid bits: cleared flag means the entry is zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg    <= '0;
            nz_rd_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                nz_reg <= '0;
            end
            else if (req.wr_en)
            begin
                nz_reg[req.wr_addr] <= (req.wr_data != 32'sd0);
            end
            if (req.rd_en)
            begin
                nz_rd_reg <= nz_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = nz_rd_reg ? mem_rd_reg : 32'sd0;
    assign nz      = nz_reg;

endmodule

`default_nettype wire

### src/pcse_mac.sv
// Shared arithmetic unit: registered multiply, rounded/saturated rescale, saturating add.
`timescale 1ns / 1ps
`default_nettype none

module pcse_mac
(
    input  wire logic                  clk,
    input  wire pcse_pkg::mac_ctl_t    ctl,
    input  wire logic signed [31:0]    mul_a,
    input  wire logic signed [31:0]    mul_b,
    input  wire logic signed [31:0]    operand,
    input  wire logic signed [31:0]    coef,
    output logic signed [31:0]         sum,
    output logic                       sum_ovf,
    output logic                       scale_ovf
);

    localparam logic signed [64:0] HALF    = (65'sd1 <<< pcse_pkg::FRAC_BITS) >>> 1;
    localparam logic signed [64:0] S32_MAX = 65'sd2147483647;
    localparam logic signed [64:0] S32_MIN = -65'sd2147483648;

    logic signed [63:0] prod_reg;
    logic signed [31:0] scaled_reg;
    logic               scale_ovf_reg;

    logic signed [64:0] rounded;
    logic signed [64:0] shifted;
    logic signed [31:0] scaled_next;
    logic               scale_ovf_next;
    logic signed [31:0] add_a;
    logic signed [32:0] raw_sum;

    // round half up, floor shift, clamp to 32 bits
    always_comb
    begin
        rounded = 65'(prod_reg) + HALF;
        shifted = rounded >>> pcse_pkg::FRAC_BITS;
        scale_ovf_next = 1'b0;
        if (shifted > S32_MAX)
        begin
            scaled_next    = 32'sh7FFF_FFFF;
            scale_ovf_next = 1'b1;
        end
        else if (shifted < S32_MIN)
        begin
            scaled_next    = -32'sh8000_0000;
            scale_ovf_next = 1'b1;
        end
        else
        begin
            scaled_next = shifted[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        end
        if (ctl.scale_en)
        begin
            scaled_reg    <= scaled_next;
            scale_ovf_reg <= scale_ovf_next;
        end
    end

    always_comb
    begin
        add_a   = ctl.use_scaled ? scaled_reg : operand;
        raw_sum = 33'(add_a) + 33'(coef);
        sum_ovf = raw_sum[32] ^ raw_sum[31];
        if (sum_ovf)
        begin
            sum = raw_sum[32] ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            sum = raw_sum[31:0];
        end
    end

    assign scale_ovf = scale_ovf_reg;

endmodule

`default_nettype wire

### src/pcse_checker.sv
// Port-level checker for the coefficient store core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pcse_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [2:0]         operation,
    input wire logic               done,
    input wire logic signed [31:0] result_value,
    input wire logic [4:0]         top_degree,
    input wire logic               overflow_flag
);

    // an accepted beat keeps the core busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after accepted beat");

    // result beat lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // clear passes through S_EXEC to a done beat with zero value, degree and flag
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == pcse_pkg::OP_CLEAR) |=> ##1
        (done && result_value == 32'sd0 && top_degree == 5'd0 && !overflow_flag))
        else $error("clear result wrong");

    // read passes through S_EXEC to a done beat and never flags overflow
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == pcse_pkg::OP_READ) |=> ##1 (done && !overflow_flag))
        else $error("read result wrong");

endmodule

bind polynomial_coefficient_store_eval_core pcse_checker u_pcse_checker (.*);

`default_nettype wire
